// ===== sv/lrp_pkg.sv =====
package lrp_pkg;

  // Fixed-point layout of the trig registers and the projection
  localparam int TRIG_FRAC = 14;
  localparam logic signed [8:0] PROJ_SCALE = 9'sd240;  // screen half-width, tan(90/2) = 1

  localparam int SCR_W = 16;
  localparam logic signed [SCR_W-1:0] SCR_MAX = 16'sh7fff;
  localparam logic signed [SCR_W-1:0] SCR_MIN = 16'sh8000;

  localparam int TRIG_W     = 16;
  localparam int DIST_W     = 16;
  localparam int OFFSET_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic signed [TRIG_W-1:0] RST_COS       = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] RST_SIN       = 16'sd0;
  localparam logic signed [DIST_W-1:0] RST_EYE_DIST  = 16'sd1280;
  localparam logic [OFFSET_W-1:0]      RST_OFFSET    = 10'd150;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_X     = 3'd0,
    CFG_SIN_X     = 3'd1,
    CFG_COS_Y     = 3'd2,
    CFG_SIN_Y     = 3'd3,
    CFG_COS_Z     = 3'd4,
    CFG_SIN_Z     = 3'd5,
    CFG_EYE_DIST  = 3'd6,
    CFG_OFFSET    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_z;
    logic signed [TRIG_W-1:0] sin_z;
  } trig_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic             vld;
    logic             fault;
    logic [SCR_W-1:0] scr_x;
    logic [SCR_W-1:0] scr_y;
  } lane_res_t;

  // One output word
  typedef struct packed {
    logic             fault;
    logic [SCR_W-1:0] start_x;
    logic [SCR_W-1:0] start_y;
    logic [SCR_W-1:0] end_x;
    logic [SCR_W-1:0] end_y;
  } out_word_t;

endpackage

// ===== sv/lrp_rot.sv =====
// One plane rotation: p = (a*c + b*s) >>> 14, q = (b*c - a*s) >>> 14.
// Two stages: products, then sum and shift. A third coordinate rides along.
module lrp_rot
  import lrp_pkg::*;
#(
  parameter int IW = 16,
  parameter int OW = 19,
  parameter int PW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [IW-1:0]     a_i,
  input  logic signed [IW-1:0]     b_i,
  input  logic [PW-1:0]            pass_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  output logic                     vld_o,
  output logic signed [OW-1:0]     p_o,
  output logic signed [OW-1:0]     q_o,
  output logic [PW-1:0]            pass_o
);

  localparam int MW = IW + TRIG_W;

  logic signed [MW-1:0] ac_r, as_r, bc_r, bs_r;
  logic signed [MW-1:0] ac_nxt, as_nxt, bc_nxt, bs_nxt;
  logic [PW-1:0]        pass0_r, pass1_r;
  logic                 vld0_r, vld1_r;
  logic signed [MW:0]   sum_p, sum_q;
  logic signed [OW-1:0] p_r, q_r, p_nxt, q_nxt;

  // Stage 0: four products
  assign ac_nxt = a_i * cos_i;
  assign as_nxt = a_i * sin_i;
  assign bc_nxt = b_i * cos_i;
  assign bs_nxt = b_i * sin_i;

  // Stage 1: full-precision sums, arithmetic shift by the trig fraction
  assign sum_p = ac_r + bs_r;
  assign sum_q = bc_r - as_r;
  assign p_nxt = sum_p[OW+TRIG_FRAC-1:TRIG_FRAC];
  assign q_nxt = sum_q[OW+TRIG_FRAC-1:TRIG_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
    end else if (en_i) begin
      vld0_r <= vld_i;
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      ac_r    <= ac_nxt;
      as_r    <= as_nxt;
      bc_r    <= bc_nxt;
      bs_r    <= bs_nxt;
      pass0_r <= pass_i;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      pass1_r <= pass0_r;
    end
  end

  assign vld_o  = vld1_r;
  assign p_o    = p_r;
  assign q_o    = q_r;
  assign pass_o = pass1_r;

endmodule

// ===== sv/lrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor. Quotients truncate toward zero.
module lrp_div
  import lrp_pkg::*;
#(
  parameter int NW = 29,
  parameter int DW = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [NW-1:0] nx_i,
  input  logic signed [NW-1:0] ny_i,
  input  logic signed [DW-1:0] d_i,
  output logic                vld_o,
  output logic                zero_o,
  output logic signed [NW:0]  qx_o,
  output logic signed [NW:0]  qy_o
);

  // Stage k holds the remainders, the dividend/quotient shift words and
  // the divisor magnitude after k quotient bits.
  logic [DW-1:0] rem_x_r [NW+1];
  logic [DW-1:0] rem_y_r [NW+1];
  logic [NW-1:0] sh_x_r  [NW+1];
  logic [NW-1:0] sh_y_r  [NW+1];
  logic [DW-1:0] dv_r    [NW+1];
  logic          neg_x_r [NW+1];
  logic          neg_y_r [NW+1];
  logic          zero_r  [NW+1];
  logic          vld_r   [NW+1];

  logic [NW-1:0] mag_x, mag_y;
  logic [DW-1:0] mag_d;

  logic signed [NW:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic               zero_out_r, vld_out_r;

  // Load: magnitudes and result signs
  assign mag_x = nx_i[NW-1] ? NW'(-nx_i) : NW'(nx_i);
  assign mag_y = ny_i[NW-1] ? NW'(-ny_i) : NW'(ny_i);
  assign mag_d = d_i[DW-1]  ? DW'(-d_i)  : DW'(d_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en_i) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      rem_x_r[0] <= '0;
      rem_y_r[0] <= '0;
      sh_x_r[0]  <= mag_x;
      sh_y_r[0]  <= mag_y;
      dv_r[0]    <= mag_d;
      neg_x_r[0] <= nx_i[NW-1] ^ d_i[DW-1];
      neg_y_r[0] <= ny_i[NW-1] ^ d_i[DW-1];
      zero_r[0]  <= (d_i == '0);
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0]   trial_x, trial_y;
    logic          take_x, take_y;
    logic [DW-1:0] rem_x_nxt, rem_y_nxt;

    always_comb begin
      trial_x   = {rem_x_r[k], sh_x_r[k][NW-1]};
      trial_y   = {rem_y_r[k], sh_y_r[k][NW-1]};
      take_x    = (trial_x >= {1'b0, dv_r[k]});
      take_y    = (trial_y >= {1'b0, dv_r[k]});
      rem_x_nxt = take_x ? DW'(trial_x - {1'b0, dv_r[k]}) : trial_x[DW-1:0];
      rem_y_nxt = take_y ? DW'(trial_y - {1'b0, dv_r[k]}) : trial_y[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_x_r[k+1] <= rem_x_nxt;
        rem_y_r[k+1] <= rem_y_nxt;
        sh_x_r[k+1]  <= {sh_x_r[k][NW-2:0], take_x};
        sh_y_r[k+1]  <= {sh_y_r[k][NW-2:0], take_y};
        dv_r[k+1]    <= dv_r[k];
        neg_x_r[k+1] <= neg_x_r[k];
        neg_y_r[k+1] <= neg_y_r[k];
        zero_r[k+1]  <= zero_r[k];
      end
    end
  end

  // Restore the signs
  assign qx_nxt = neg_x_r[NW] ? -$signed({1'b0, sh_x_r[NW]}) : $signed({1'b0, sh_x_r[NW]});
  assign qy_nxt = neg_y_r[NW] ? -$signed({1'b0, sh_y_r[NW]}) : $signed({1'b0, sh_y_r[NW]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en_i) begin
      vld_out_r <= vld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      qx_r       <= qx_nxt;
      qy_r       <= qy_nxt;
      zero_out_r <= zero_r[NW];
    end
  end

  assign vld_o  = vld_out_r;
  assign zero_o = zero_out_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;

endmodule

// ===== sv/lrp_lane.sv =====
// One endpoint: three plane rotations, projection setup, divide, offset
// and saturate.
module lrp_lane
  import lrp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] z_i,
  input  trig_t                         trig_i,
  input  logic signed [DIST_W-1:0]      dist_i,
  input  logic [OFFSET_W-1:0]           offset_i,
  output lane_res_t                     res_o
);

  // Growth through the rotations with unnormalized trig pairs
  localparam int R1 = COORD_WIDTH + 3;  // after x-y
  localparam int R2 = COORD_WIDTH + 4;  // after x-z
  localparam int R3 = COORD_WIDTH + 5;  // after z-y
  localparam int DW = R3 + 1;           // depth plus eye distance
  localparam int NW = R3 + 8;           // coordinate times screen scale
  localparam int SW = NW + 2;           // quotient plus offset

  logic                 vld1, vld2, vld3;
  logic signed [R1-1:0] x1, y1, z_ext;
  logic [COORD_WIDTH-1:0] z_d;
  logic signed [R2-1:0] x2, z1, y1_ext;
  logic [R1-1:0]        y1_d;
  logic signed [R3-1:0] z2, y2;
  logic [R2-1:0]        x2_d;

  // x-y plane by angle two
  lrp_rot #(.IW(COORD_WIDTH), .OW(R1), .PW(COORD_WIDTH)) u_rot_xy (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (en_i),
    .vld_i  (vld_i),
    .a_i    (x_i),
    .b_i    (y_i),
    .pass_i (z_i),
    .cos_i  (trig_i.cos_z),
    .sin_i  (trig_i.sin_z),
    .vld_o  (vld1),
    .p_o    (x1),
    .q_o    (y1),
    .pass_o (z_d)
  );

  assign z_ext = R1'(signed'(z_d));

  // x-z plane by angle one
  lrp_rot #(.IW(R1), .OW(R2), .PW(R1)) u_rot_xz (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (en_i),
    .vld_i  (vld1),
    .a_i    (x1),
    .b_i    (z_ext),
    .pass_i (y1),
    .cos_i  (trig_i.cos_y),
    .sin_i  (trig_i.sin_y),
    .vld_o  (vld2),
    .p_o    (x2),
    .q_o    (z1),
    .pass_o (y1_d)
  );

  assign y1_ext = R2'(signed'(y1_d));

  // z-y plane by angle zero
  lrp_rot #(.IW(R2), .OW(R3), .PW(R2)) u_rot_zy (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (en_i),
    .vld_i  (vld2),
    .a_i    (z1),
    .b_i    (y1_ext),
    .pass_i (x2),
    .cos_i  (trig_i.cos_x),
    .sin_i  (trig_i.sin_x),
    .vld_o  (vld3),
    .p_o    (z2),
    .q_o    (y2),
    .pass_o (x2_d)
  );

  // Projection setup: denominator and scaled numerators
  logic                 prj_vld_r;
  logic signed [DW-1:0] d_r, d_nxt;
  logic signed [NW-1:0] nx_r, ny_r, nx_nxt, ny_nxt;

  assign d_nxt  = DW'(z2) + DW'(dist_i);
  assign nx_nxt = signed'(x2_d) * PROJ_SCALE;
  assign ny_nxt = y2 * PROJ_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prj_vld_r <= 1'b0;
    end else if (en_i) begin
      prj_vld_r <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      d_r  <= d_nxt;
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
    end
  end

  // Divide
  logic               div_vld, div_zero;
  logic signed [NW:0] qx, qy;

  lrp_div #(.NW(NW), .DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (en_i),
    .vld_i  (prj_vld_r),
    .nx_i   (nx_r),
    .ny_i   (ny_r),
    .d_i    (d_r),
    .vld_o  (div_vld),
    .zero_o (div_zero),
    .qx_o   (qx),
    .qy_o   (qy)
  );

  // Offset and saturate; a zero denominator gives zero coordinates
  logic signed [SW-1:0] off_ext, sum_x, sum_y;
  logic [SCR_W-1:0]     scr_x, scr_y;
  lane_res_t            res_r, res_nxt;

  assign off_ext = signed'({{(SW-OFFSET_W){1'b0}}, offset_i});
  assign sum_x   = SW'(qx) + off_ext;
  assign sum_y   = SW'(qy) + off_ext;

  always_comb begin
    if (sum_x > SCR_MAX) begin
      scr_x = SCR_MAX;
    end else if (sum_x < SCR_MIN) begin
      scr_x = SCR_MIN;
    end else begin
      scr_x = sum_x[SCR_W-1:0];
    end
    if (sum_y > SCR_MAX) begin
      scr_y = SCR_MAX;
    end else if (sum_y < SCR_MIN) begin
      scr_y = SCR_MIN;
    end else begin
      scr_y = sum_y[SCR_W-1:0];
    end
  end

  always_comb begin
    res_nxt.vld   = div_vld;
    res_nxt.fault = div_zero;
    res_nxt.scr_x = div_zero ? '0 : scr_x;
    res_nxt.scr_y = div_zero ? '0 : scr_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.vld <= 1'b0;
    end else if (en_i) begin
      res_r.vld <= res_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      res_r.fault <= res_nxt.fault;
      res_r.scr_x <= res_nxt.scr_x;
      res_r.scr_y <= res_nxt.scr_y;
    end
  end

  assign res_o = res_r;

endmodule

// ===== sv/line_rotate_project_unit.sv =====
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | in_start_x/y/z, in_end_x/y/z (COORD_WIDTH, Q8.8)
// out     | out_valid / out_ready  | out_screen_start_x/y, out_screen_end_x/y, out_divide_fault
// cfg     | cfg_wr_en              | cfg_index, cfg_wdata (write only, no wait)
//
// One word per cycle sustained while the output buffer is not full; each endpoint has its own lane.
// The divider resolves one quotient bit per stage over COORD_WIDTH + 13 stages.
// Reset is synchronous; registers return to identity rotation, distance 5.0,
// offset 150.
// The pipeline advances as a whole; a two-word output buffer keeps in_ready
// high while one finished word waits, and drops it only when both are full.
module line_rotate_project_unit
  import lrp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SCR_W-1:0]       out_screen_start_x,
  output logic signed [SCR_W-1:0]       out_screen_start_y,
  output logic signed [SCR_W-1:0]       out_screen_end_x,
  output logic signed [SCR_W-1:0]       out_screen_end_y,
  output logic                          out_divide_fault,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  // Configuration registers
  trig_t                     trig_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic [OFFSET_W-1:0]       offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.cos_x <= RST_COS;
      trig_r.sin_x <= RST_SIN;
      trig_r.cos_y <= RST_COS;
      trig_r.sin_y <= RST_SIN;
      trig_r.cos_z <= RST_COS;
      trig_r.sin_z <= RST_SIN;
      dist_r       <= RST_EYE_DIST;
      offset_r     <= RST_OFFSET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COS_X:    trig_r.cos_x <= cfg_wdata;
        CFG_SIN_X:    trig_r.sin_x <= cfg_wdata;
        CFG_COS_Y:    trig_r.cos_y <= cfg_wdata;
        CFG_SIN_Y:    trig_r.sin_y <= cfg_wdata;
        CFG_COS_Z:    trig_r.cos_z <= cfg_wdata;
        CFG_SIN_Z:    trig_r.sin_z <= cfg_wdata;
        CFG_EYE_DIST: dist_r       <= cfg_wdata;
        CFG_OFFSET:   offset_r     <= cfg_wdata[OFFSET_W-1:0];
        default:      ;
      endcase
    end
  end

  // Pipeline advance: stall only when the output buffer is full
  logic adv;
  logic skid_vld_r;

  assign adv      = !skid_vld_r;
  assign in_ready = adv;

  // Endpoint lanes
  lane_res_t res_start, res_end;

  lrp_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_start (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (adv),
    .vld_i    (in_valid),
    .x_i      (in_start_x),
    .y_i      (in_start_y),
    .z_i      (in_start_z),
    .trig_i   (trig_r),
    .dist_i   (dist_r),
    .offset_i (offset_r),
    .res_o    (res_start)
  );

  lrp_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_end (
    .clk      (clk),
    .rst_n    (rst_n),
    .en_i     (adv),
    .vld_i    (in_valid),
    .x_i      (in_end_x),
    .y_i      (in_end_y),
    .z_i      (in_end_z),
    .trig_i   (trig_r),
    .dist_i   (dist_r),
    .offset_i (offset_r),
    .res_o    (res_end)
  );

  // Merge the two lanes into one word
  out_word_t merged;
  logic      push, pop;

  always_comb begin
    merged.fault   = res_start.fault | res_end.fault;
    merged.start_x = res_start.scr_x;
    merged.start_y = res_start.scr_y;
    merged.end_x   = res_end.scr_x;
    merged.end_y   = res_end.scr_y;
  end

  assign push = adv && res_start.vld && res_end.vld;

  // Output register plus skid word
  out_word_t out_word_r, skid_word_r;
  logic      out_vld_r;

  assign pop = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_word_r <= skid_word_r;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_word_r <= merged;
      end else begin
        out_word_r <= merged;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_screen_start_x = out_word_r.start_x;
  assign out_screen_start_y = out_word_r.start_y;
  assign out_screen_end_x   = out_word_r.end_x;
  assign out_screen_end_y   = out_word_r.end_y;
  assign out_divide_fault   = out_word_r.fault;

endmodule

// ===== sv/lrp_checker.sv =====
module lrp_checker
  import lrp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SCR_W-1:0] out_screen_start_x,
  input logic signed [SCR_W-1:0] out_screen_start_y,
  input logic signed [SCR_W-1:0] out_screen_end_x,
  input logic signed [SCR_W-1:0] out_screen_end_y,
  input logic                    out_divide_fault
);

  // A stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_screen_start_x)
      && $stable(out_screen_end_y) && $stable(out_divide_fault))
    else $error("output word dropped or changed while stalled");

  // A fault word has at least one endpoint forced to the origin
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |->
      (out_screen_start_x == '0 && out_screen_start_y == '0) ||
      (out_screen_end_x == '0 && out_screen_end_y == '0))
    else $error("fault word with both endpoints projected");

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output buffer not empty after reset");

  // Input backpressure only while a finished word is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output register");

endmodule

bind line_rotate_project_unit lrp_checker u_lrp_checker (.*);

// ===== bench/lrp_screen_checker.sv =====
// Watches both channels and the register port of line_rotate_project_unit.
// Keeps its own copy of the registers, predicts the screen word for every
// accepted segment word and compares result words in order.
module lrp_screen_checker
  import lrp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SCR_W-1:0]       out_screen_start_x,
  input  logic signed [SCR_W-1:0]       out_screen_start_y,
  input  logic signed [SCR_W-1:0]       out_screen_end_x,
  input  logic signed [SCR_W-1:0]       out_screen_end_y,
  input  logic                          out_divide_fault,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output int                            mismatch_count,
  output int                            words_in_flight
);

  // Shadow registers
  trig_t                      trig = '{RST_COS, RST_SIN, RST_COS, RST_SIN, RST_COS, RST_SIN};
  logic signed [DIST_W-1:0]   eye_dist = RST_EYE_DIST;
  logic [OFFSET_W-1:0]        scr_offset = RST_OFFSET;

  out_word_t expected_screens[$];
  out_word_t want;
  int        errs = 0;

  function automatic logic [SCR_W-1:0] clamp_screen(input longint v);
    if (v > longint'(SCR_MAX)) return SCR_MAX;
    if (v < longint'(SCR_MIN)) return SCR_MIN;
    return v[SCR_W-1:0];
  endfunction

  // x-y turn, then x-z, then z-y; floor after each Q1.14 product sum,
  // then divide by depth plus eye distance (truncating toward zero)
  function automatic logic project_endpoint(input longint x, input longint y, input longint z,
                                            output logic [SCR_W-1:0] col,
                                            output logic [SCR_W-1:0] row);
    longint cx, sx, cy, sy, cz, sz;
    longint x1, y1, x2, z1, z2, y2, den;
    cx = longint'($signed(trig.cos_x));
    sx = longint'($signed(trig.sin_x));
    cy = longint'($signed(trig.cos_y));
    sy = longint'($signed(trig.sin_y));
    cz = longint'($signed(trig.cos_z));
    sz = longint'($signed(trig.sin_z));
    x1 = (x * cz + y * sz) >>> TRIG_FRAC;
    y1 = (y * cz - x * sz) >>> TRIG_FRAC;
    x2 = (x1 * cy + z * sy) >>> TRIG_FRAC;
    z1 = (z * cy - x1 * sy) >>> TRIG_FRAC;
    z2 = (z1 * cx + y1 * sx) >>> TRIG_FRAC;
    y2 = (y1 * cx - z1 * sx) >>> TRIG_FRAC;
    den = z2 + longint'($signed(eye_dist));
    if (den == 0) begin
      col = '0;
      row = '0;
      return 1'b1;
    end
    col = clamp_screen(x2 * longint'(PROJ_SCALE) / den + longint'(scr_offset));
    row = clamp_screen(y2 * longint'(PROJ_SCALE) / den + longint'(scr_offset));
    return 1'b0;
  endfunction

  function automatic out_word_t predict_screens();
    out_word_t w;
    logic      fault_a, fault_b;
    fault_a = project_endpoint(longint'(in_start_x), longint'(in_start_y),
                               longint'(in_start_z), w.start_x, w.start_y);
    fault_b = project_endpoint(longint'(in_end_x), longint'(in_end_y),
                               longint'(in_end_z), w.end_x, w.end_y);
    w.fault = fault_a | fault_b;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [SCR_W-1:0] exp_v,
                             input logic [SCR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trig       = '{RST_COS, RST_SIN, RST_COS, RST_SIN, RST_COS, RST_SIN};
      eye_dist   = RST_EYE_DIST;
      scr_offset = RST_OFFSET;
      expected_screens.delete();
    end else begin
      // segment word accepted: queue its screen word
      if (in_valid && in_ready)
        expected_screens.push_back(predict_screens());

      // screen word accepted: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_screens.size() == 0) begin
          $error("screen word with no segment outstanding");
          errs++;
        end else begin
          want = expected_screens.pop_front();
          check_field("screen_start_x", want.start_x, out_screen_start_x);
          check_field("screen_start_y", want.start_y, out_screen_start_y);
          check_field("screen_end_x", want.end_x, out_screen_end_x);
          check_field("screen_end_y", want.end_y, out_screen_end_y);
          check_field("divide_fault", SCR_W'(want.fault), SCR_W'(out_divide_fault));
        end
      end

      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_COS_X:    trig.cos_x = cfg_wdata;
          CFG_SIN_X:    trig.sin_x = cfg_wdata;
          CFG_COS_Y:    trig.cos_y = cfg_wdata;
          CFG_SIN_Y:    trig.sin_y = cfg_wdata;
          CFG_COS_Z:    trig.cos_z = cfg_wdata;
          CFG_SIN_Z:    trig.sin_z = cfg_wdata;
          CFG_EYE_DIST: eye_dist = cfg_wdata;
          CFG_OFFSET:   scr_offset = cfg_wdata[OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count  <= errs;
    words_in_flight <= expected_screens.size();
  end

endmodule

// ===== bench/line_rotate_project_unit_tb.sv =====
module line_rotate_project_unit_tb;
  import lrp_pkg::*;

  localparam int COORD_WIDTH = 16;
  localparam int LATENCY     = COORD_WIDTH + 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 100;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_WIDTH-1:0] in_start_x = '0;
  logic signed [COORD_WIDTH-1:0] in_start_y = '0;
  logic signed [COORD_WIDTH-1:0] in_start_z = '0;
  logic signed [COORD_WIDTH-1:0] in_end_x = '0;
  logic signed [COORD_WIDTH-1:0] in_end_y = '0;
  logic signed [COORD_WIDTH-1:0] in_end_z = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SCR_W-1:0]       out_screen_start_x;
  logic signed [SCR_W-1:0]       out_screen_start_y;
  logic signed [SCR_W-1:0]       out_screen_end_x;
  logic signed [SCR_W-1:0]       out_screen_end_y;
  logic                          out_divide_fault;
  logic                          cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

  int mismatch_count;
  int words_in_flight;
  int cycle_count = 0;

  // stimulus knobs
  int                       send_idle_pct = 0;
  int                       stall_pct = 0;
  logic                     hold_req = 1'b0;
  int                       hold_cnt = 0;
  logic signed [DIST_W-1:0] cur_dist = RST_EYE_DIST;

  line_rotate_project_unit #(.COORD_WIDTH(COORD_WIDTH)) dut (.*);

  lrp_screen_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!hold_req) hold_cnt <= 0;
    end
  end

  task automatic send_segment(input segment_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= s.sx;
    in_start_y <= s.sy;
    in_start_z <= s.sz;
    in_end_x   <= s.ex;
    in_end_y   <= s.ey;
    in_end_z   <= s.ez;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and let every outstanding word come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // writes all eight registers; junk goes into the bits above the offset
  task automatic load_registers(input logic signed [TRIG_W-1:0] cx, input logic signed [TRIG_W-1:0] sx,
                                input logic signed [TRIG_W-1:0] cy, input logic signed [TRIG_W-1:0] sy,
                                input logic signed [TRIG_W-1:0] cz, input logic signed [TRIG_W-1:0] sz,
                                input logic signed [DIST_W-1:0] dist_val,
                                input logic [OFFSET_W-1:0] offset);
    cfg_write(CFG_COS_X, cx);
    cfg_write(CFG_SIN_X, sx);
    cfg_write(CFG_COS_Y, cy);
    cfg_write(CFG_SIN_Y, sy);
    cfg_write(CFG_COS_Z, cz);
    cfg_write(CFG_SIN_Z, sz);
    cfg_write(CFG_EYE_DIST, dist_val);
    cfg_write(CFG_OFFSET, {6'($urandom_range(63)), offset});
    cfg_wr_en <= 1'b0;
    cur_dist = dist_val;
    @(posedge clk);
  endtask

  function automatic logic signed [TRIG_W-1:0] random_trig();
    return TRIG_W'(int'($urandom_range(32768)) - 16384);
  endfunction

  // mostly small coordinates so the picture stays on screen, some full range
  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return COORD_WIDTH'($urandom);
    if (pick < 85) return COORD_WIDTH'(int'($urandom_range(4096)) - 2048);
    return COORD_WIDTH'(int'($urandom_range(32768)) - 16384);
  endfunction

  // when depth survives the rotation, z = -distance hits a zero divisor
  function automatic segment_t random_segment(input bit depth_kept);
    segment_t s;
    int       pick;
    s = '{random_coord(), random_coord(), random_coord(),
          random_coord(), random_coord(), random_coord()};
    pick = $urandom_range(99);
    if (depth_kept && pick < 12) begin
      if (pick < 5 || pick >= 10) s.sz = -cur_dist;
      if (pick >= 5) s.ez = -cur_dist;
    end
    return s;
  endfunction

  task automatic run_phase(input int idle, input int stall, input bit depth_kept,
                           input bit hold);
    send_idle_pct = idle;
    stall_pct    <= stall;
    hold_req     <= hold;
    repeat (PHASE_WORDS) send_segment(random_segment(depth_kept));
    drain();
    hold_req     <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words on reset registers: identity, distance 5.0, offset 150
    send_segment('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_segment('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_segment('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    // zero divisor on one endpoint only, then on both
    send_segment('{16'sd256, 16'sd512, -16'sd1280, 16'sd256, 16'sd256, 16'sd256});
    send_segment('{16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100, -16'sd1280});
    send_segment('{16'sd999, -16'sd77, -16'sd1280, -16'sd5, 16'sd3, -16'sd1280});
    // divisor of one: both saturation limits
    send_segment('{16'sh7fff, 16'sh8000, -16'sd1279, 16'sh8000, 16'sh7fff, -16'sd1279});
    // tiny divisors of either sign, quotient rounds toward zero
    send_segment('{16'sd1000, -16'sd1000, -16'sd1281, -16'sd5, 16'sd5, -16'sd1273});
    send_segment('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    send_segment('{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});
    drain();

    // identity, zero distance and offset: z = 0 faults
    load_registers(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 10'd0);
    run_phase(0, 0, 1'b1, 1'b0);

    // extremes: unnormalized pairs, most negative distance, largest offset
    load_registers(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
                   16'sh8000, 10'd1023);
    run_phase(52, 0, 1'b0, 1'b0);

    // turn in the x-y plane only
    load_registers(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, random_trig(), random_trig(),
                   DIST_W'($urandom_range(4096)), OFFSET_W'($urandom));
    run_phase(0, 52, 1'b1, 1'b0);

    load_registers(random_trig(), random_trig(), random_trig(), random_trig(), random_trig(),
                   random_trig(), DIST_W'($urandom), OFFSET_W'($urandom));
    run_phase(11, 11, 1'b0, 1'b0);

    // long receiver hold-off while the sender keeps pushing
    load_registers(random_trig(), random_trig(), random_trig(), random_trig(), random_trig(),
                   random_trig(), DIST_W'($urandom_range(8192)), OFFSET_W'($urandom));
    run_phase(0, 0, 1'b0, 1'b1);

    // half turns about x and y leave depth unchanged
    load_registers(-16'sd16384, 16'sd0, -16'sd16384, 16'sd0, random_trig(), random_trig(),
                   16'sh7fff, 10'd0);
    run_phase(52, 0, 1'b1, 1'b0);

    load_registers(random_trig(), random_trig(), random_trig(), random_trig(), random_trig(),
                   random_trig(), DIST_W'($urandom), OFFSET_W'($urandom));
    run_phase(0, 52, 1'b0, 1'b0);

    load_registers(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384,
                   16'sd1, 10'd512);
    run_phase(11, 11, 1'b0, 1'b0);

    if (mismatch_count == 0 && words_in_flight == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lrp_pkg.sv
sv/lrp_rot.sv
sv/lrp_div.sv
sv/lrp_lane.sv
sv/line_rotate_project_unit.sv
sv/lrp_checker.sv
bench/lrp_screen_checker.sv
bench/line_rotate_project_unit_tb.sv
